>>> rtl/crcd_pkg.sv
// ============================================================================
// crcd_pkg
// Shared types, constants and the byte-wide CRC-16/MODBUS update.
// ============================================================================
package crcd_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] LEN_MIN     = 16'd9;
    localparam logic [15:0] LEN_MAX     = 16'd32767;
    localparam logic [15:0] HDR_BYTES   = 16'd9;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam int          OUT_DATA_W  = 72;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;
    localparam logic [1:0] ST_CRC_ERR = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // one queue entry: an optional payload word and an optional verdict
    typedef struct packed {
        logic        has_payload;
        logic        has_verdict;
        logic [7:0]  payload_byte;
        logic [7:0]  command;
        logic [31:0] address;
        logic [14:0] payload_length;
        logic [1:0]  status;
    } entry_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

>>> rtl/crcd_front.sv
// ============================================================================
// crcd_front
// Parses header, tracks CRC and byte count, classifies each byte.
// ============================================================================
module crcd_front import crcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        end_of_datagram,
    output logic        push,
    output entry_t      push_entry
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  command_reg, command_next;
    logic [31:0] address_reg, address_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rx_crc_reg, rx_crc_next;

    logic        len_ok;
    logic [15:0] len_m2;
    logic        crc_en;
    logic        is_payload;
    logic [1:0]  status;
    logic [15:0] len_m9;

    always_comb
    begin
        length_next  = length_reg;
        command_next = command_reg;
        address_next = address_reg;
        unique case (byte_count_reg)
            16'd0:   length_next = {length_reg[15:8], in_byte};
            16'd1:   length_next = {in_byte, length_reg[7:0]};
            16'd2:   command_next = in_byte;
            16'd3:   address_next[7:0]   = in_byte;
            16'd4:   address_next[15:8]  = in_byte;
            16'd5:   address_next[23:16] = in_byte;
            16'd6:   address_next[31:24] = in_byte;
            default: ;
        endcase

        len_ok = (length_next >= LEN_MIN) && (length_next <= LEN_MAX);
        len_m2 = length_next - 16'd2;
        len_m9 = length_next - HDR_BYTES;

        crc_en   = (byte_count_reg < 16'd2) || (len_ok && (byte_count_reg < len_m2));
        crc_next = crc_en ? crc_byte(crc_reg, in_byte) : crc_reg;

        rx_crc_next = rx_crc_reg;
        if (len_ok && (byte_count_reg == len_m2))
            rx_crc_next = {rx_crc_reg[15:8], in_byte};
        else if (len_ok && (byte_count_reg == length_next - 16'd1))
            rx_crc_next = {in_byte, rx_crc_reg[7:0]};

        is_payload = len_ok && (byte_count_reg >= 16'd7) && (byte_count_reg < len_m2);

        byte_count_next = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                        : byte_count_reg + 16'd1;

        priority if (byte_count_next < LEN_MIN)
            status = ST_SHORT;
        else if (!len_ok)
            status = ST_BAD_LEN;
        else if (byte_count_next < length_next)
            status = ST_BAD_LEN;
        else if (crc_next != rx_crc_next)
            status = ST_CRC_ERR;
        else
            status = ST_OK;

        push_entry.has_payload    = is_payload;
        push_entry.has_verdict    = end_of_datagram;
        push_entry.payload_byte   = in_byte;
        push_entry.command        = command_next;
        push_entry.address        = address_next;
        push_entry.payload_length = len_ok ? len_m9[14:0] : 15'd0;
        push_entry.status         = status;
        push = accept && (is_payload || end_of_datagram);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            length_reg     <= '0;
            command_reg    <= '0;
            address_reg    <= '0;
            crc_reg        <= CRC_INIT;
            rx_crc_reg     <= '0;
        end
        else if (accept)
        begin
            if (end_of_datagram)
            begin
                byte_count_reg <= '0;
                length_reg     <= '0;
                command_reg    <= '0;
                address_reg    <= '0;
                crc_reg        <= CRC_INIT;
                rx_crc_reg     <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                length_reg     <= length_next;
                command_reg    <= command_next;
                address_reg    <= address_next;
                crc_reg        <= crc_next;
                rx_crc_reg     <= rx_crc_next;
            end
        end
    end

endmodule

>>> rtl/crcd_queue.sv
// ============================================================================
// crcd_queue
// Two-entry register FIFO between the front and back parts.
// ============================================================================
module crcd_queue import crcd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

>>> rtl/crcd_back.sv
// ============================================================================
// crcd_back
// Expands queue entries into output words through an output register.
// ============================================================================
module crcd_back import crcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  entry_t                head_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_kind,
    output logic                  out_last
);

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_kind_reg, out_kind_next;
    logic                  out_last_reg, out_last_next;
    logic                  phase_reg, phase_next;
    logic                  load;
    logic                  emit_payload;

    assign load         = (!out_valid_reg || out_ready) && head_valid;
    assign emit_payload = head_entry.has_payload && !phase_reg;

    always_comb
    begin
        pop        = 1'b0;
        phase_next = phase_reg;
        if (emit_payload)
        begin
            out_kind_next = KIND_PAYLOAD;
            out_last_next = !head_entry.has_verdict;
            out_data_next = {64'd0, head_entry.payload_byte};
            if (load)
            begin
                if (head_entry.has_verdict)
                    phase_next = 1'b1;
                else
                    pop = 1'b1;
            end
        end
        else
        begin
            out_kind_next = KIND_VERDICT;
            out_last_next = 1'b1;
            // pad, status, length, address, command, zero payload byte
            out_data_next = {7'd0, head_entry.status, head_entry.payload_length,
                             head_entry.address, head_entry.command, 8'd0};
            if (load)
            begin
                pop        = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
            out_kind_reg <= out_kind_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head_valid && head_entry.has_verdict && head_entry.has_payload))
        else $error("second half of pair without matching entry");
    a_pair_split: assert property (@(posedge clk) disable iff (!rst_n)
        (load && emit_payload && head_entry.has_verdict) |=> phase_reg)
        else $error("payload of pair sent without pending verdict");
`endif

endmodule

>>> rtl/crc16_frame_deframer_core.sv
// Path: a byte accepted at an edge is written into the queue, and its first word
// is then loaded from the queue head into the output register.
// Throughput: one byte per cycle while the queue is not full; a payload byte that
// ends the datagram yields two output words, both expanded from one queue entry.
// The front CRC/byte-count update is a combinational byte-wide step.
// Reset: rst_n is asynchronous, active low; clears frame state (CRC to 0xFFFF).
// ============================================================================
// crc16_frame_deframer_core
// Byte-stream deframer for length-prefixed frames with CRC-16/MODBUS check.
// Forwards payload bytes and ends each datagram with one verdict word.
// ============================================================================
module crc16_frame_deframer_core import crcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] in_byte
    input  logic                  s_axis_tlast,   // end_of_datagram
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] payload_byte, [15:8] command, [47:16] address,
    // [62:48] payload_length, [64:63] status, [71:65] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser,   // kind: 0 payload, 1 verdict
    output logic                  m_axis_tlast    // last word for the input byte
);

    // front/back handshake through the queue
    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   q_full;
    logic   pop;
    logic   head_valid;
    entry_t head_entry;

    // the queue drains one entry per cycle, so it only fills when the
    // output side stalls or a two-word entry is being expanded
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    crcd_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .in_byte         (s_axis_tdata),
        .end_of_datagram (s_axis_tlast),
        .push            (push),
        .push_entry      (push_entry)
    );

    crcd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    crcd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_kind   (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

>>> sim/crcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcd_checker
// Watches both streams of the deframer, predicts the words it must produce for
// every accepted byte and compares each output word against the oldest one.
// ----------------------------------------------------------------------------
module crcd_checker import crcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int                    mismatches,
    output int                    pending,
    output int                    payload_words,
    output int                    verdict_words
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  cmd;
        logic [31:0] addr;
        logic [14:0] plen;
        logic [1:0]  status;
        logic        last;
    } deframe_word_t;

    deframe_word_t pending_words[$];

    // shadow frame state
    logic [15:0] rx_count;
    logic [15:0] frame_len;
    logic [7:0]  frame_cmd;
    logic [31:0] frame_addr;
    logic [15:0] run_crc;
    logic [15:0] rx_crc;

    function automatic logic [15:0] modbus_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8)
        begin
            if (r[0])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    task automatic clear_frame();
        rx_count   = '0;
        frame_len  = '0;
        frame_cmd  = '0;
        frame_addr = '0;
        run_crc    = CRC_INIT;
        rx_crc     = '0;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch @%0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // next-state and expected words for one accepted byte
    task automatic deframe_byte(input logic [7:0] b, input logic eod);
        logic [15:0]   pos;
        logic          len_valid;
        deframe_word_t w;
        pos = rx_count;
        if (pos == 16'd0)
            frame_len[7:0] = b;
        else if (pos == 16'd1)
            frame_len[15:8] = b;
        else if (pos == 16'd2)
            frame_cmd = b;
        else if (pos >= 16'd3 && pos <= 16'd6)
            frame_addr[8*(pos-3) +: 8] = b;

        len_valid = (frame_len >= LEN_MIN) && (frame_len <= LEN_MAX);

        // CRC runs over the length bytes always, the rest only with a sane length
        if (pos < 16'd2 || (len_valid && pos < frame_len - 16'd2))
            run_crc = modbus_step(run_crc, b);

        if (len_valid)
        begin
            if (pos == frame_len - 16'd2)
                rx_crc[7:0] = b;
            else if (pos == frame_len - 16'd1)
                rx_crc[15:8] = b;
            if (pos >= 16'd7 && pos < frame_len - 16'd2)
            begin
                w = '0;
                w.kind      = KIND_PAYLOAD;
                w.data_byte = b;
                w.last      = !eod;
                pending_words.push_back(w);
            end
        end

        if (rx_count != COUNT_MAX)
            rx_count++;

        if (eod)
        begin
            w = '0;
            w.kind = KIND_VERDICT;
            w.cmd  = frame_cmd;
            w.addr = frame_addr;
            w.plen = len_valid ? 15'(frame_len - HDR_BYTES) : 15'd0;
            w.last = 1'b1;
            if (rx_count < HDR_BYTES)
                w.status = ST_SHORT;
            else if (!len_valid || rx_count < frame_len)
                w.status = ST_BAD_LEN;
            else if (run_crc != rx_crc)
                w.status = ST_CRC_ERR;
            else
                w.status = ST_OK;
            pending_words.push_back(w);
            clear_frame();
        end
    endtask

    task automatic check_word();
        deframe_word_t w;
        if (pending_words.size() == 0)
        begin
            note_mismatch("word with nothing pending", m_tdata[31:0], 32'd0);
            return;
        end
        w = pending_words.pop_front();
        if (w.kind == KIND_PAYLOAD)
            payload_words++;
        else
            verdict_words++;
        if (m_tuser !== w.kind)
            note_mismatch("kind", m_tuser, w.kind);
        if (m_tdata[7:0] !== w.data_byte)
            note_mismatch("payload_byte", m_tdata[7:0], w.data_byte);
        if (m_tdata[15:8] !== w.cmd)
            note_mismatch("command", m_tdata[15:8], w.cmd);
        if (m_tdata[47:16] !== w.addr)
            note_mismatch("address", m_tdata[47:16], w.addr);
        if (m_tdata[62:48] !== w.plen)
            note_mismatch("payload_length", m_tdata[62:48], w.plen);
        if (m_tdata[64:63] !== w.status)
            note_mismatch("status", m_tdata[64:63], w.status);
        if (m_tdata[71:65] !== 7'd0)
            note_mismatch("pad bits", m_tdata[71:65], 32'd0);
        if (m_tlast !== w.last)
            note_mismatch("last", m_tlast, w.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            pending_words.delete();
            mismatches    = 0;
            payload_words = 0;
            verdict_words = 0;
        end
        else
        begin
            // input first, so a same-cycle result would still find its entry
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_word();
        end
        pending = pending_words.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives datagrams into the CRC-16 deframer: a few directed corner frames, a
// random mix of good and broken frames, then a few frames with both sides
// running flat out. Checking is done by crcd_checker.
// ----------------------------------------------------------------------------
module tb;
    import crcd_pkg::*;

    localparam int LIMIT       = 1_000_000;  // cycles
    localparam int HOLD_CYCLES = 400;        // long output back-pressure
    localparam int RANDOM_BYTES = 500;
    localparam int SETTLE      = 20;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    int mismatches, pending, payload_words, verdict_words;
    int cycles = 0;
    int bytes_sent = 0;
    int dgrams_sent = 0;

    logic sender_idle = 1'b0;
    logic rx_idle = 1'b1;
    logic quiet = 1'b0;     // both sides run flat out
    logic hold_req = 1'b0;

    logic [7:0] dgram[$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    crc16_frame_deframer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    crcd_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .s_tlast       (s_axis_tlast),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .m_tuser       (m_axis_tuser),
        .m_tlast       (m_axis_tlast),
        .mismatches    (mismatches),
        .pending       (pending),
        .payload_words (payload_words),
        .verdict_words (verdict_words)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // one word per handshake; valid stays up across back-to-back words
    task automatic put_word(input logic [7:0] b, input logic eod);
        int gap;
        gap = (sender_idle && !quiet) ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = eod;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_dgram();
        foreach (dgram[i])
            put_word(dgram[i], i == dgram.size() - 1);
        bytes_sent  += dgram.size();
        dgrams_sent++;
    endtask

    // well-formed frame with random payload and a correct CRC
    task automatic make_frame(input int plen, input logic [7:0] cmd, input logic [31:0] addr);
        logic [15:0] len;
        logic [15:0] crc;
        len = 16'(plen + 9);
        dgram.delete();
        dgram.push_back(len[7:0]);
        dgram.push_back(len[15:8]);
        dgram.push_back(cmd);
        for (int k = 0; k < 4; k++)
            dgram.push_back(addr[8*k +: 8]);
        repeat (plen)
            dgram.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (dgram[i])
            crc = crc_byte(crc, dgram[i]);
        dgram.push_back(crc[7:0]);
        dgram.push_back(crc[15:8]);
    endtask

    // receiver: random per-word stall, plus one long hold-off on request
    initial
    begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 39) == 0)
                rx_idle = !rx_idle;
            gap = (rx_idle && !quiet) ? $urandom_range(0, 14) : 0;
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    initial
    begin
        int          sel;
        int          plen;
        int          cut;
        logic [15:0] bad_len;
        logic        hold_used;
        hold_used = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed corners ---
        sender_idle = 1'b1;
        // lone zero byte with the end flag: short datagram, nothing captured
        dgram = '{8'h00};
        send_dgram();
        // minimum frame, all-ones command and address, two trailing bytes past L
        make_frame(0, 8'hFF, 32'hFFFF_FFFF);
        dgram.push_back(8'hFF);
        dgram.push_back(8'h00);
        send_dgram();
        // length field 0xFFFF: invalid, no payload forwarded
        make_frame(0, 8'h00, 32'h0000_0000);
        dgram[0] = 8'hFF;
        dgram[1] = 8'hFF;
        send_dgram();
        // frame cut on its first payload byte: payload word then a short verdict
        make_frame(2, 8'h5A, 32'h1234_5678);
        while (dgram.size() > 8)
            void'(dgram.pop_back());
        send_dgram();

        // --- random mix, mostly well-formed ---
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (!hold_used && bytes_sent >= 150)
            begin
                hold_used = 1'b1;
                hold_req  = 1'b1;
            end
            sender_idle = ($urandom_range(0, 3) != 0);
            sel  = $urandom_range(0, 99);
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
            make_frame(plen, 8'($urandom), $urandom);
            if (sel >= 60 && sel < 70)
            begin
                // flip one bit of the received CRC
                cut = dgram.size() - 1 - $urandom_range(0, 1);
                dgram[cut] = dgram[cut] ^ 8'(1 << $urandom_range(0, 7));
            end
            else if (sel >= 70 && sel < 78)
            begin
                cut = $urandom_range(1, dgram.size() - 1);
                while (dgram.size() > cut)
                    void'(dgram.pop_back());
            end
            else if (sel >= 78 && sel < 85)
            begin
                repeat ($urandom_range(1, 6))
                    dgram.push_back(8'($urandom));
            end
            else if (sel >= 85 && sel < 92)
            begin
                bad_len = $urandom_range(0, 1) ? 16'($urandom_range(0, 8))
                                                : 16'($urandom_range(32768, 65535));
                dgram.delete();
                dgram.push_back(bad_len[7:0]);
                dgram.push_back(bad_len[15:8]);
                repeat ($urandom_range(0, 18))
                    dgram.push_back(8'($urandom));
            end
            else if (sel >= 92)
            begin
                dgram.delete();
                repeat ($urandom_range(1, 20))
                    dgram.push_back(8'($urandom));
            end
            send_dgram();
        end

        // --- a few frames with both sides flat out ---
        quiet = 1'b1;
        make_frame(40, 8'($urandom), $urandom);
        send_dgram();
        // short valid frame followed by trailing bytes
        make_frame(3, 8'($urandom), $urandom);
        repeat (8)
            dgram.push_back(8'($urandom));
        send_dgram();
        quiet = 1'b0;

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d datagrams / %0d bytes: good, bad-CRC, cut, trailing, bad-length",
                 dgrams_sent, bytes_sent);
        $display("and noise frames, a long output stall and flat-out traffic; %0d %s",
                 payload_words + verdict_words, "output words checked");
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
